// ----- hdl/itr_pkg.sv -----
package itr_pkg;

    // Fixed field widths of the channels
    localparam int VALUE_W = 32;
    localparam int BASE_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;

    // Digit store
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = 5;
    localparam int CNT_W       = 6;

    // Radix limits and special characters
    localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_W-1:0] BASE_TEN  = 6'd10;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    // Restoring division bits retired per cycle
    localparam int BITS_PER_CYCLE = 8;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 6'd10) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else if (d < 6'd36) begin
            c = CHAR_LOW_A + CHAR_W'(d - 6'd10);
        end else begin
            c = CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

// ----- hdl/itr_in_if.sv -----
interface itr_in_if
    import itr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               signed_mode;
    logic [BASE_W-1:0]  base;

    modport source (output valid, value, signed_mode, base, input ready);
    modport sink   (input valid, value, signed_mode, base, output ready);
endinterface

// ----- hdl/itr_out_if.sv -----
interface itr_out_if
    import itr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              bad_base;

    modport source (output valid, character, last, bad_base, input ready);
    modport sink   (input valid, character, last, bad_base, output ready);
endinterface

// ----- hdl/itr_divider.sv -----
module itr_divider
    import itr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [DIGIT_W-1:0]     i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [DIGIT_W-1:0]     o_remainder
);

    localparam int STEPS  = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PAD_W  = STEPS * BITS_PER_CYCLE;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [PAD_W-1:0]  r_shift, n_shift;
    logic [DIGIT_W-1:0] r_rem, n_rem;
    logic [DIGIT_W-1:0] r_div, n_div;

    logic [PAD_W-1:0]   s_shift;
    logic [DIGIT_W-1:0] s_rem;

    // Several restoring steps per cycle; dividend bits leave at the top,
    // quotient bits enter at the bottom.
    always_comb begin
        logic [DIGIT_W:0] t;
        s_rem   = r_rem;
        s_shift = r_shift;
        for (int k = 0; k < BITS_PER_CYCLE; k++) begin
            t       = {s_rem, s_shift[PAD_W-1]};
            s_shift = {s_shift[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                t          = t - {1'b0, r_div};
                s_shift[0] = 1'b1;
            end
            s_rem = t[DIGIT_W-1:0];
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_step  = r_step;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_start) begin
            n_busy  = 1'b1;
            n_step  = STEP_W'(STEPS);
            n_shift = PAD_W'(i_dividend);
            n_rem   = '0;
            n_div   = i_divisor;
        end else if (r_busy) begin
            n_shift = s_shift;
            n_rem   = s_rem;
            n_step  = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_step  <= '0;
            r_shift <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_step  <= n_step;
            r_shift <= n_shift;
        end
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_shift[VALUE_WIDTH-1:0];
    assign o_remainder = r_rem;

endmodule

// ----- hdl/itr_digit_store.sv -----
module itr_digit_store
    import itr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [STORE_AW-1:0] i_waddr,
    input  logic [DIGIT_W-1:0]  i_wdata,
    input  logic                i_re,
    input  logic [STORE_AW-1:0] i_raddr,
    output logic [DIGIT_W-1:0]  o_rdata
);

    logic [DIGIT_W-1:0] r_mem [STORE_DEPTH];
    logic [DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/integer_to_radix_text_core.sv -----
// Integer to radix text converter.
//
// i_in carries value, signed_mode and base; o_out returns one beat per
// character (lower-case ASCII digits, most significant first) with last on
// the final one. In signed mode with base ten a negative value is sent as
// '-' followed by its magnitude. A base outside 2..36 returns a single beat
// with character 0, last and bad_base set.
//
// One conversion at a time: i_in.ready is high only while the block is
// idle. Digits come from a shared divider that retires 8 quotient bits per
// cycle and then hands back the result, one division per digit. Up to 32
// digits are produced before the first character leaves. Each character
// then passes through digit store read, output load and handoff; a stalled
// sink simply holds the output beat, nothing is lost. A bad base is
// answered straight from idle, without the divider.
//
// Reset is synchronous, active low; it idles the sequencer and drops
// o_out.valid. The digit store needs no clearing.
module integer_to_radix_text_core
    import itr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itr_in_if.sink    i_in,
    itr_out_if.source o_out
);

    localparam int IN_W = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic [STORE_AW-1:0] r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic                r_out_last, n_out_last;
    logic                r_out_bad, n_out_bad;

    logic [VALUE_WIDTH-1:0] s_value;
    logic [VALUE_WIDTH-1:0] s_mag;
    logic                   s_in_neg;
    logic                   s_base_ok;
    logic                   s_in_fire;
    logic                   s_out_fire;
    logic [CNT_W-1:0]       s_cnt_inc;

    logic                   s_div_start;
    logic [VALUE_WIDTH-1:0] s_div_dividend;
    logic [DIGIT_W-1:0]     s_div_divisor;
    logic                   s_div_done;
    logic [VALUE_WIDTH-1:0] s_div_quo;
    logic [DIGIT_W-1:0]     s_div_rem;

    logic                   s_we;
    logic                   s_re;
    logic [DIGIT_W-1:0]     s_rdata;

    assign s_in_fire  = i_in.valid && i_in.ready;
    assign s_out_fire = o_out.valid && o_out.ready;

    assign s_value   = VALUE_WIDTH'(i_in.value[IN_W-1:0]);
    assign s_base_ok = (i_in.base >= BASE_MIN) && (i_in.base <= BASE_MAX);
    assign s_in_neg  = i_in.signed_mode && (i_in.base == BASE_TEN) && s_value[VALUE_WIDTH-1];
    assign s_mag     = s_in_neg ? (~s_value + VALUE_WIDTH'(1)) : s_value;

    // Digits beyond the store depth are dropped, the count saturates
    assign s_cnt_inc = r_cnt[CNT_W-1] ? r_cnt : (r_cnt + CNT_W'(1));

    assign s_div_dividend = (r_state == S_IDLE) ? s_mag : s_div_quo;
    assign s_div_divisor  = (r_state == S_IDLE) ? i_in.base : r_base;
    assign s_we = (r_state == S_DIV) && s_div_done && !r_cnt[CNT_W-1];
    assign s_re = (r_state == S_RD);

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        s_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_in_fire) begin
                    if (!s_base_ok) begin
                        n_out_valid = 1'b1;
                        n_out_char  = CHAR_NUL;
                        n_out_last  = 1'b1;
                        n_out_bad   = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        n_base      = i_in.base;
                        n_cnt       = '0;
                        n_neg       = s_in_neg;
                        s_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (s_div_done) begin
                    n_cnt = s_cnt_inc;
                    if (s_div_quo != '0) begin
                        s_div_start = 1'b1;
                    end else begin
                        n_idx = STORE_AW'(s_cnt_inc - CNT_W'(1));
                        // a full store leaves no room for the sign
                        n_neg = r_neg && !s_cnt_inc[CNT_W-1];
                        if (n_neg) begin
                            n_out_valid = 1'b1;
                            n_out_char  = CHAR_MINUS;
                            n_out_last  = 1'b0;
                            n_out_bad   = 1'b0;
                            n_state     = S_OUT;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_out_valid = 1'b1;
                n_out_char  = digit_char(s_rdata);
                n_out_last  = (r_idx == '0);
                n_out_bad   = 1'b0;
                n_idx       = r_idx - STORE_AW'(1);
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (s_out_fire) begin
                    n_out_valid = 1'b0;
                    n_state     = r_out_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
        r_base     <= n_base;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    itr_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_div_start),
        .i_dividend  (s_div_dividend),
        .i_divisor   (s_div_divisor),
        .o_done      (s_div_done),
        .o_quotient  (s_div_quo),
        .o_remainder (s_div_rem)
    );

    itr_digit_store u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_cnt[STORE_AW-1:0]),
        .i_wdata (s_div_rem),
        .i_re    (s_re),
        .i_raddr (r_idx),
        .o_rdata (s_rdata)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;
    assign o_out.bad_base  = r_out_bad;

endmodule
